// ----- hdl/sws_pkg.sv -----
// Shared types and constants of the sliding-window sender.
// Used by sws_ctrl, sws_dpath and sliding_window_sender_unit.
`timescale 1ns / 1ps
package sws_pkg;

  localparam int SEGMENT_BYTES = 1024;
  localparam int MAX_BURST     = 64;

  localparam int WORD_W    = 32;
  localparam int WIN_W     = 16;
  localparam int DUP_W     = 3;
  localparam int SEG_LEN_W = 11;
  localparam int LEN_W     = $clog2(SEGMENT_BYTES + 1);
  localparam int CNT_W     = $clog2(MAX_BURST + 1);

  localparam logic [DUP_W-1:0]  DUP_LIMIT      = 3'd7;
  localparam logic [WIN_W-1:0]  CREDIT_MAX     = 16'hFFFF;
  localparam logic [WIN_W-1:0]  WINDOW_RST     = 16'd10240;
  localparam logic [WORD_W-1:0] FIRST_SEQ_RST  = 32'd1;

  // input opcodes
  localparam logic [1:0] OP_POLL = 2'd0;
  localparam logic [1:0] OP_ACK  = 2'd1;

  // result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_RESET  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_TOTAL_BYTES    = 2'd0;
  localparam logic [1:0] REG_FIRST_SEQ      = 2'd1;
  localparam logic [1:0] REG_INITIAL_WINDOW = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POLL,
    ST_CHECK,
    ST_ACK_CALC,
    ST_ACK_CMP,
    ST_ACK_APPLY,
    ST_RESP
  } sws_state_t;

  typedef struct packed {
    logic in_load;
    logic rewind;
    logic seg_take;
    logic seg_emit;
    logic seg_last;
    logic resp_emit;
    logic ack_calc;
    logic ack_cmp;
    logic ack_apply;
  } sws_cmd_t;

  typedef struct packed {
    logic go;
    logic have_seg;
    logic out_free;
  } sws_stat_t;

endpackage

// ----- hdl/sws_ctrl.sv -----
// Controller of the sliding-window sender: sequences polls, ACKs and resets.
// Depends on sws_pkg; drives sws_dpath through sws_cmd_t.
`timescale 1ns / 1ps
module sws_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  output logic              in_ready,
  input  sws_pkg::sws_stat_t stat,
  output sws_pkg::sws_cmd_t  cmd
);
  import sws_pkg::*;

  sws_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_POLL) begin
            state_next = ST_POLL;
          end else if (in_op == OP_ACK) begin
            state_next = ST_ACK_CALC;
          end else begin
            state_next = ST_RESP;
          end
        end
      end
      ST_POLL:      state_next = ST_CHECK;
      ST_CHECK: begin
        if (!stat.have_seg) begin
          if (!stat.go) begin
            state_next = ST_RESP;
          end
        end else if (stat.out_free && !stat.go) begin
          state_next = ST_IDLE;
        end
      end
      ST_ACK_CALC:  state_next = ST_ACK_CMP;
      ST_ACK_CMP:   state_next = ST_ACK_APPLY;
      ST_ACK_APPLY: state_next = ST_RESP;
      ST_RESP: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.in_load = in_valid;
      end
      ST_POLL: cmd.rewind = 1'b1;
      ST_CHECK: begin
        if (!stat.have_seg) begin
          cmd.seg_take = stat.go;
        end else if (stat.out_free) begin
          cmd.seg_emit = 1'b1;
          cmd.seg_last = !stat.go;
          cmd.seg_take = stat.go;
        end
      end
      ST_ACK_CALC:  cmd.ack_calc  = 1'b1;
      ST_ACK_CMP:   cmd.ack_cmp   = 1'b1;
      ST_ACK_APPLY: cmd.ack_apply = 1'b1;
      ST_RESP:      cmd.resp_emit = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ----- hdl/sws_dpath.sv -----
// Datapath of the sliding-window sender: configuration, window state,
// segment arithmetic and the output register. Depends on sws_pkg.
`timescale 1ns / 1ps
module sws_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [sws_pkg::WORD_W-1:0]  cfg_data,
  input  logic [1:0]                  in_op,
  input  logic                        in_timer,
  input  logic [sws_pkg::WORD_W-1:0]  in_ack,
  input  logic [sws_pkg::WIN_W-1:0]   in_adv,
  input  sws_pkg::sws_cmd_t           cmd,
  output sws_pkg::sws_stat_t          stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_kind,
  output logic [sws_pkg::WORD_W-1:0]  out_seq,
  output logic [sws_pkg::SEG_LEN_W-1:0] out_len,
  output logic                        out_done,
  output logic                        out_last
);
  import sws_pkg::*;

  logic [WORD_W-1:0] total_bytes, first_seq;
  logic [WIN_W-1:0]  initial_window;

  logic [WORD_W-1:0] acked_offset, send_offset;
  logic [WIN_W-1:0]  window_credit;
  logic [DUP_W-1:0]  dup_count;
  logic              transfer_done;

  logic [1:0]        op_r;
  logic              timer_r;
  logic [WORD_W-1:0] ack_r;
  logic [WIN_W-1:0]  adv_r;
  logic [WORD_W-1:0] off_r, diff_r;
  logic              hit_r, eq_r, gt_r;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] seg_seq_r;
  logic [LEN_W-1:0]  seg_len_r;

  logic [WORD_W-1:0] remain;
  logic [LEN_W-1:0]  len;
  logic              more, enough;
  logic [WORD_W:0]   credit_sum;
  logic [DUP_W-1:0]  dup_inc;
  logic              out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_bytes    <= '0;
      first_seq      <= FIRST_SEQ_RST;
      initial_window <= WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOTAL_BYTES:    total_bytes    <= cfg_data;
        REG_FIRST_SEQ:      first_seq      <= cfg_data;
        REG_INITIAL_WINDOW: initial_window <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    remain     = total_bytes - send_offset;
    more       = send_offset < total_bytes;
    len        = (remain < WORD_W'(SEGMENT_BYTES)) ? remain[LEN_W-1:0]
                                                   : LEN_W'(SEGMENT_BYTES);
    enough     = window_credit >= WIN_W'(len);
    credit_sum = {{(WORD_W + 1 - WIN_W){1'b0}}, window_credit} + {1'b0, diff_r};
    dup_inc    = dup_count + 1'b1;
    out_free   = !out_valid || out_ready;
  end

  assign stat.go       = more && enough && (cnt < CNT_W'(MAX_BURST));
  assign stat.have_seg = cnt != '0;
  assign stat.out_free = out_free;

  // input item, ACK pipeline and segment registers
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op_r    <= in_op;
      timer_r <= in_timer;
      ack_r   <= in_ack;
      adv_r   <= in_adv;
    end
    if (cmd.ack_calc) begin
      off_r <= ack_r - first_seq;
      hit_r <= (ack_r + {{(WORD_W - WIN_W){1'b0}}, adv_r}) == (total_bytes + first_seq);
    end
    if (cmd.ack_cmp) begin
      eq_r   <= off_r == acked_offset;
      gt_r   <= off_r > acked_offset;
      diff_r <= off_r - acked_offset;
    end
    if (cmd.seg_take) begin
      seg_seq_r <= first_seq + send_offset;
      seg_len_r <= len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acked_offset  <= '0;
      send_offset   <= '0;
      window_credit <= WINDOW_RST;
      dup_count     <= '0;
      transfer_done <= 1'b0;
      cnt           <= '0;
    end else begin
      if (cmd.rewind) begin
        cnt <= '0;
        if (timer_r) begin
          send_offset   <= acked_offset;
          window_credit <= initial_window;
        end
      end
      if (cmd.seg_take) begin
        cnt           <= cnt + 1'b1;
        send_offset   <= send_offset + WORD_W'(len);
        window_credit <= window_credit - WIN_W'(len);
      end
      if (cmd.ack_cmp && hit_r) begin
        transfer_done <= 1'b1;
      end
      if (cmd.ack_apply) begin
        if (eq_r) begin
          if (dup_inc == DUP_LIMIT) begin
            dup_count     <= '0;
            send_offset   <= off_r;
            window_credit <= initial_window;
          end else begin
            dup_count <= dup_inc;
          end
        end else begin
          dup_count <= '0;
          if (gt_r) begin
            acked_offset  <= off_r;
            window_credit <= (credit_sum > {{(WORD_W + 1 - WIN_W){1'b0}}, CREDIT_MAX})
                             ? CREDIT_MAX : credit_sum[WIN_W-1:0];
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.seg_emit || cmd.resp_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seg_emit) begin
      out_kind <= KIND_DATA;
      out_seq  <= seg_seq_r;
      out_len  <= SEG_LEN_W'(seg_len_r);
      out_done <= transfer_done;
      out_last <= cmd.seg_last;
    end else if (cmd.resp_emit) begin
      out_kind <= (op_r == OP_POLL || op_r == OP_ACK) ? KIND_STATUS : KIND_RESET;
      out_seq  <= first_seq + acked_offset;
      out_len  <= '0;
      out_done <= transfer_done;
      out_last <= 1'b1;
    end
  end

endmodule

// ----- hdl/sliding_window_sender_unit.sv -----
// Top level of the sliding-window (go-back-N) data sender.
// Depends on sws_pkg, sws_ctrl and sws_dpath.
//
// Usage: write total_bytes, first_seq and initial_window on the cfg port
// (index 0, 1, 2) while idle. Feed events on s_axis: tuser is the opcode
// (poll, ACK, other packet). Results leave on m_axis, tlast on the final
// result of each event.
// Operation: a poll clears its burst count, then registers its first segment
// and emits each segment while registering the next, one segment per cycle
// while m_axis_tready stays high, for n segments (n up to MAX_BURST).
// A poll that sends nothing gives one status result.
// An ACK passes three arithmetic steps then the response; any other packet
// type goes straight to the response. The controller accepts one event at a time.
// A single output register decouples the sides: a new event is accepted
// while the last result still waits. When the receiver stalls, the burst
// pauses with its state held; nothing is lost.
// Reset (synchronous rst) returns configuration and window state to their
// defaults and empties the output register.
`timescale 1ns / 1ps
module sliding_window_sender_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // timer_expired, ack_number, advertised_window
  input  logic [1:0]  s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // seq_number, seg_length, done_res
  output logic [1:0]  m_axis_tuser,  // kind
  output logic        m_axis_tlast
);
  import sws_pkg::*;

  sws_cmd_t  cmd;
  sws_stat_t stat;

  logic [WORD_W-1:0]    out_seq;
  logic [SEG_LEN_W-1:0] out_len;
  logic                 out_done;

  sws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sws_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_op     (s_axis_tuser),
    .in_timer  (s_axis_tdata[0]),
    .in_ack    (s_axis_tdata[32:1]),
    .in_adv    (s_axis_tdata[48:33]),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_seq   (out_seq),
    .out_len   (out_len),
    .out_done  (out_done),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, out_done, out_len, out_seq};

endmodule
